FILE: design/mlc_pkg.sv
// Shared types, character constants and the Morse code table of the letter codec.
// No dependencies; every other file of the block imports this package.
package mlc_pkg;

  // Longest code that the decoder stores before it flags an overflow.
  localparam int MAX_CODE_LEN = 4;
  localparam int PSYM_W       = MAX_CODE_LEN;
  localparam int PCNT_W       = $clog2(MAX_CODE_LEN + 1);

  // The table itself never holds more than four symbols.
  localparam int CODE_W      = 4;
  localparam int CLEN_W      = 3;
  localparam int NUM_LETTERS = 26;
  localparam int IDX_W       = 5;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] bits;  // symbol j in bit j, a dash is 1
  } code_t;

  // One output character offered by a producer to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } src_t;

  function automatic code_t letter_code(input logic [IDX_W-1:0] idx);
    code_t c;
    unique case (idx)
      5'd0:    c = '{len: 3'd2, bits: 4'b0010};
      5'd1:    c = '{len: 3'd4, bits: 4'b0001};
      5'd2:    c = '{len: 3'd4, bits: 4'b0101};
      5'd3:    c = '{len: 3'd3, bits: 4'b0001};
      5'd4:    c = '{len: 3'd1, bits: 4'b0000};
      5'd5:    c = '{len: 3'd4, bits: 4'b0100};
      5'd6:    c = '{len: 3'd3, bits: 4'b0011};
      5'd7:    c = '{len: 3'd4, bits: 4'b0000};
      5'd8:    c = '{len: 3'd2, bits: 4'b0000};
      5'd9:    c = '{len: 3'd4, bits: 4'b1110};
      5'd10:   c = '{len: 3'd3, bits: 4'b0101};
      5'd11:   c = '{len: 3'd4, bits: 4'b0010};
      5'd12:   c = '{len: 3'd2, bits: 4'b0011};
      5'd13:   c = '{len: 3'd2, bits: 4'b0001};
      5'd14:   c = '{len: 3'd3, bits: 4'b0111};
      5'd15:   c = '{len: 3'd4, bits: 4'b0110};
      5'd16:   c = '{len: 3'd4, bits: 4'b1011};
      5'd17:   c = '{len: 3'd3, bits: 4'b0010};
      5'd18:   c = '{len: 3'd3, bits: 4'b0000};
      5'd19:   c = '{len: 3'd1, bits: 4'b0001};
      5'd20:   c = '{len: 3'd3, bits: 4'b0100};
      5'd21:   c = '{len: 3'd4, bits: 4'b1000};
      5'd22:   c = '{len: 3'd3, bits: 4'b0110};
      5'd23:   c = '{len: 3'd4, bits: 4'b1001};
      5'd24:   c = '{len: 3'd4, bits: 4'b1101};
      5'd25:   c = '{len: 3'd4, bits: 4'b0011};
      default: c = '{len: 3'd0, bits: 4'b0000};
    endcase
    return c;
  endfunction

  // Compares a closed code against all 26 letters in parallel.
  function automatic logic [7:0] decode_letter(input logic [PSYM_W-1:0] sym,
                                               input logic [PCNT_W-1:0] cnt);
    logic [7:0] res;
    code_t      c;
    res = CH_QMARK;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      c = letter_code(IDX_W'(i));
      if (PCNT_W'(c.len) == cnt && PSYM_W'(c.bits) == sym) begin
        res = CH_UA + 8'(i);
      end
    end
    return res;
  endfunction

endpackage

FILE: design/mlc_encoder.sv
// Morse serializer: loads a letter's code into a shift register and sends one
// dot or dash per cycle while take is high, followed by a closing space. Depends on mlc_pkg.
module mlc_encoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [mlc_pkg::IDX_W-1:0] idx,
  input  logic                     take,
  output mlc_pkg::src_t            src
);
  import mlc_pkg::*;

  logic              busy_r, busy_nxt;
  logic [CODE_W-1:0] sym_r, sym_nxt;
  logic [CLEN_W-1:0] left_r, left_nxt;
  code_t             code;

  assign code = letter_code(idx);

  always_comb begin
    src.valid = busy_r;
    src.ch    = (left_r != '0) ? (sym_r[0] ? CH_DASH : CH_DOT) : CH_SPACE;
    src.last  = (left_r == '0);
  end

  always_comb begin
    busy_nxt = busy_r;
    sym_nxt  = sym_r;
    left_nxt = left_r;
    if (load) begin
      busy_nxt = 1'b1;
      sym_nxt  = code.bits;
      left_nxt = code.len;
    end else if (busy_r && take) begin
      if (left_r != '0) begin
        sym_nxt  = sym_r >> 1;
        left_nxt = left_r - CLEN_W'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
    end
    sym_r <= sym_nxt;
  end

endmodule

FILE: design/mlc_decoder.sv
// Morse collector: gathers dots and dashes into the pending code and, on a space
// or end of line, holds the matching letter or '?' for output. Depends on mlc_pkg.
module mlc_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          strobe,
  input  logic [7:0]    ch,
  input  logic          eol,
  input  logic          take,
  output mlc_pkg::src_t src
);
  import mlc_pkg::*;

  logic [PSYM_W-1:0] sym_r, sym_nxt, sym_add;
  logic [PCNT_W-1:0] cnt_r, cnt_nxt, cnt_add;
  logic              ovf_r, ovf_nxt, ovf_add;
  logic              res_valid_r, res_valid_nxt;
  logic [7:0]        res_ch_r, res_ch_nxt;
  logic              is_sym, closing;

  assign src.valid = res_valid_r;
  assign src.ch    = res_ch_r;
  assign src.last  = 1'b1;

  always_comb begin
    is_sym  = (ch == CH_DOT) || (ch == CH_DASH);
    sym_add = sym_r;
    cnt_add = cnt_r;
    ovf_add = ovf_r;
    if (is_sym) begin
      if (cnt_r < PCNT_W'(MAX_CODE_LEN)) begin
        for (int i = 0; i < PSYM_W; i++) begin
          if (cnt_r == PCNT_W'(i) && ch == CH_DASH) begin
            sym_add[i] = 1'b1;
          end
        end
        cnt_add = cnt_r + PCNT_W'(1);
      end else begin
        ovf_add = 1'b1;
      end
    end
    // A symbol that arrives with end of line is stored before the code closes.
    closing = ((ch == CH_SPACE) || eol) && (cnt_add != '0);

    sym_nxt       = sym_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    res_valid_nxt = res_valid_r && !take;
    res_ch_nxt    = res_ch_r;
    if (strobe) begin
      if (closing) begin
        sym_nxt       = '0;
        cnt_nxt       = '0;
        ovf_nxt       = 1'b0;
        res_valid_nxt = 1'b1;
        res_ch_nxt    = ovf_add ? CH_QMARK : decode_letter(sym_add, cnt_add);
      end else begin
        sym_nxt = sym_add;
        cnt_nxt = cnt_add;
        ovf_nxt = ovf_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      sym_r       <= sym_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      res_valid_r <= res_valid_nxt;
    end
    res_ch_r <= res_ch_nxt;
  end

endmodule

FILE: design/morse_letter_codec.sv
// Top level of the Morse letter codec: input decode, encoder and decoder
// instances, and the output register. Depends on mlc_pkg, mlc_encoder, mlc_decoder.
//
// Usage: each input word carries in_mode, in_char_in and in_end_of_line and is
// taken when in_valid is high and in_stall is low. Result words leave on the
// out_ channel (out_char_out, out_last_in_run), taken when out_valid is high
// and out_stall is low; out_last_in_run marks the final word of an input word.
// Encode mode: a letter (either case) gives its dots and dashes, one per cycle
// from a shift register unless stalled, then a space. Other characters give nothing.
// Decode mode: dots and dashes build the pending code; a space or end of line
// closes a non-empty code and gives one letter, or '?' for no match.
// Each result word is held in the encoder or decoder state first and then in the
// output register, which drives out_valid.
// The input takes no new word while the encoder or decoder holds a result word:
// an encoded letter blocks it until its space is passed on, a closing decode word
// until its letter is passed on; a word with no result does not raise in_stall.
// A stall on the output holds the output register; the serializer waits and
// in_stall stays high until every word of the current item has been moved on.
// Reset (synchronous, rst_n low) clears the pending code and empties all stages.
module morse_letter_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_last_in_run
);
  import mlc_pkg::*;

  src_t       enc_src, dec_src;
  logic       in_acc, load_ok, is_letter, enc_load, dec_strobe;
  logic [7:0] upper, offs;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_ch_r, out_ch_nxt;
  logic       out_last_r, out_last_nxt;

  assign in_stall = enc_src.valid || dec_src.valid;
  assign in_acc   = in_valid && !in_stall;
  assign load_ok  = !out_valid_r || !out_stall;

  always_comb begin
    upper = ((in_char_in >= CH_LA) && (in_char_in <= CH_LZ)) ? in_char_in - CASE_OFS
                                                              : in_char_in;
    is_letter  = (upper >= CH_UA) && (upper <= CH_UZ);
    offs       = upper - CH_UA;
    enc_load   = in_acc && (in_mode == MODE_ENC) && is_letter;
    dec_strobe = in_acc && (in_mode == MODE_DEC);
  end

  mlc_encoder u_enc (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (enc_load),
    .idx   (offs[IDX_W-1:0]),
    .take  (load_ok),
    .src   (enc_src)
  );

  mlc_decoder u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (dec_strobe),
    .ch     (in_char_in),
    .eol    (in_end_of_line),
    .take   (load_ok),
    .src    (dec_src)
  );

  // Only one producer can hold a word at a time, since input waits on both.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;
    if (load_ok) begin
      out_valid_nxt = enc_src.valid || dec_src.valid;
      out_ch_nxt    = enc_src.valid ? enc_src.ch : dec_src.ch;
      out_last_nxt  = enc_src.valid ? enc_src.last : dec_src.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_ch_r;
  assign out_last_in_run = out_last_r;

endmodule

FILE: test/morse_letter_codec_test.sv
// Self-checking testbench of morse_letter_codec: directed and random character words in
// both modes, random gaps and output stalls, results checked against a local model.
// Depends on mlc_pkg and the RTL of morse_letter_codec.
module morse_letter_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc_pkg::*;

  localparam int RANDOM_WORDS = 234;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic       mode;
    logic [7:0] ch;
    logic       eol;
  } char_word_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } morse_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = MODE_ENC;
  logic [7:0] in_char_in = 8'h00;
  logic       in_end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char_out;
  logic       out_last_in_run;

  morse_letter_codec i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_char_in      (in_char_in),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_last_in_run (out_last_in_run)
  );

  always #5 clk = ~clk;

  char_word_t    char_q[$];
  morse_result_t morse_q[$];
  char_word_t    cur_word;

  // Local copy of the pending decode code.
  logic [3:0] code_bits = '0;
  int         code_len = 0;
  logic       code_ovf = 1'b0;

  int  words_accepted = 0;
  int  results_checked = 0;
  int  letters_decoded = 0;
  int  qmarks_decoded = 0;
  int  failures = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;

  function automatic string morse_of(input int idx);
    case (idx)
      0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
      4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
      8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
      12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
      16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
      20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
      24: return "-.--";  default: return "--..";
    endcase
  endfunction

  function automatic logic [7:0] letter_of_code();
    string      s;
    logic [3:0] bits;
    if (code_ovf) return CH_QMARK;
    for (int i = 0; i < 26; i++) begin
      s = morse_of(i);
      bits = '0;
      for (int j = 0; j < s.len(); j++) begin
        if (s[j] == CH_DASH) bits[j] = 1'b1;
      end
      if (s.len() == code_len && bits == code_bits) return CH_UA + 8'(i);
    end
    return CH_QMARK;
  endfunction

  // Works out the result words of one accepted word and advances the pending code.
  function automatic void predict_codec(input char_word_t w);
    logic [7:0]    c;
    logic [7:0]    letter;
    string         s;
    morse_result_t r;
    c = w.ch;
    if (w.mode == MODE_ENC) begin
      if (c >= CH_LA && c <= CH_LZ) c = c - CASE_OFS;
      if (c >= CH_UA && c <= CH_UZ) begin
        s = morse_of(int'(c - CH_UA));
        for (int j = 0; j < s.len(); j++) begin
          r.ch = s[j];
          r.last = 1'b0;
          morse_q.push_back(r);
        end
        r.ch = CH_SPACE;
        r.last = 1'b1;
        morse_q.push_back(r);
      end
    end else begin
      if (c == CH_DOT || c == CH_DASH) begin
        if (code_len < MAX_CODE_LEN) begin
          if (c == CH_DASH) code_bits[code_len] = 1'b1;
          code_len++;
        end else begin
          code_ovf = 1'b1;
        end
      end
      if ((c == CH_SPACE || w.eol) && code_len > 0) begin
        letter = letter_of_code();
        r.ch = letter;
        r.last = 1'b1;
        morse_q.push_back(r);
        letters_decoded++;
        if (letter == CH_QMARK) qmarks_decoded++;
        code_bits = '0;
        code_len = 0;
        code_ovf = 1'b0;
      end
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  function automatic void add_word(input logic mode, input logic [7:0] ch, input logic eol);
    char_word_t w;
    w.mode = mode;
    w.ch = ch;
    w.eol = eol;
    char_q.push_back(w);
  endfunction

  function automatic void report_mismatch(input string what, input logic [7:0] exp_v,
                                          input logic [7:0] act_v);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s expected 0x%02h, got 0x%02h",
               results_checked, what, exp_v, act_v);
    end
  endfunction

  // Driver: a new word is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_codec(cur_word);
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          cur_word = char_q.pop_front();
          in_mode <= cur_word.mode;
          in_char_in <= cur_word.ch;
          in_end_of_line <= cur_word.eol;
          in_valid <= 1'b1;
          if ($urandom_range(39) == 0) in_calm = !in_calm;
          gap_left = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every taken result word and plays the stalling receiver.
  always @(posedge clk) begin
    morse_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (morse_q.size() == 0) begin
          report_mismatch("unexpected word, char_out", 8'h00, out_char_out);
        end else begin
          e = morse_q.pop_front();
          if (out_char_out !== e.ch) report_mismatch("char_out", e.ch, out_char_out);
          if (out_last_in_run !== e.last) begin
            report_mismatch("last_in_run", 8'(e.last), 8'(out_last_in_run));
          end
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(49) == 0) out_calm = !out_calm;
        stall_left = pick_gap(out_calm);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still queued, %0d results outstanding",
               cycle_count, char_q.size(), morse_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int         counted;
    int         pick;
    int         n_sym;
    bit         eol_close;
    logic [7:0] c;
    string      s;

    // Encoding: both cases, field extremes and the characters just below A and just above z.
    add_word(MODE_ENC, CH_UA, 1'b0);
    add_word(MODE_ENC, CH_LZ, 1'b1);
    add_word(MODE_ENC, 8'h00, 1'b0);
    add_word(MODE_ENC, 8'hFF, 1'b1);
    add_word(MODE_ENC, CH_UA - 8'd1, 1'b0);
    add_word(MODE_ENC, CH_LZ + 8'd1, 1'b0);
    // A pending code survives encode words and an encode end of line.
    add_word(MODE_DEC, CH_DASH, 1'b0);
    add_word(MODE_DEC, CH_DOT, 1'b0);
    add_word(MODE_ENC, 8'h65, 1'b0);
    add_word(MODE_ENC, CH_SPACE, 1'b1);
    add_word(MODE_DEC, CH_SPACE, 1'b0);
    // Closing an empty code gives nothing.
    add_word(MODE_DEC, CH_SPACE, 1'b0);
    add_word(MODE_DEC, 8'h78, 1'b1);
    // Five dashes overflow the code; another character with end of line closes it.
    repeat (5) add_word(MODE_DEC, CH_DASH, 1'b0);
    add_word(MODE_DEC, 8'h71, 1'b1);
    // Four symbols with no matching letter, closed by a dash with end of line.
    add_word(MODE_DEC, CH_DOT, 1'b0);
    add_word(MODE_DEC, CH_DASH, 1'b0);
    add_word(MODE_DEC, CH_DOT, 1'b0);
    add_word(MODE_DEC, CH_DASH, 1'b1);
    // A dot with end of line is stored before the code closes.
    add_word(MODE_DEC, CH_DASH, 1'b0);
    add_word(MODE_DEC, CH_DASH, 1'b0);
    add_word(MODE_DEC, CH_DOT, 1'b1);

    // Random part: mostly well-formed letters in both directions, some long codes, some noise.
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        c = CH_UA + 8'($urandom_range(25));
        if ($urandom_range(1)) c = c + CASE_OFS;
        add_word(MODE_ENC, c, 1'($urandom_range(1)));
        counted++;
      end else if (pick < 72) begin
        s = morse_of($urandom_range(25));
        eol_close = ($urandom_range(2) == 0);
        for (int j = 0; j < s.len(); j++) begin
          add_word(MODE_DEC, s[j], eol_close && (j == s.len() - 1));
          counted++;
        end
        if (!eol_close) begin
          add_word(MODE_DEC, CH_SPACE, ($urandom_range(3) == 0));
          counted++;
        end
        if ($urandom_range(5) == 0) begin
          add_word(MODE_DEC, CH_SPACE, 1'b0);
          counted++;
        end
      end else if (pick < 80) begin
        n_sym = $urandom_range(7, 4);
        for (int j = 0; j < n_sym; j++) begin
          add_word(MODE_DEC, $urandom_range(1) ? CH_DASH : CH_DOT, 1'b0);
          counted++;
        end
        add_word(MODE_DEC, CH_SPACE, 1'($urandom_range(1)));
        counted++;
      end else begin
        add_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        counted++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || in_valid || morse_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (morse_q.size() > 0) begin
      $display("%0d expected result words never arrived", morse_q.size());
      failures += morse_q.size();
    end
    $display("Sent %0d character words in encode and decode mode; checked %0d result words.",
             words_accepted, results_checked);
    $display("Decoder closed %0d codes, %0d of them unmatched or too long; %0d mismatches.",
             letters_decoded, qmarks_decoded, failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
